/* rtl/wts_pkg.sv */
// shared constants, codes and types for the whitespace token splitter
package wts_pkg;

  localparam int BYTE_W            = 8;
  localparam int OUT_POS_W         = 16;
  localparam int POS_BITS_DEFAULT  = 16;

  // scan mode codes
  localparam logic [1:0] MODE_SKIP    = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_TOKEN   = 2'd2;
  localparam logic [1:0] MODE_QUOTED  = 2'd3;

  // byte class codes
  localparam logic [1:0] CLASS_SEP     = 2'd0;
  localparam logic [1:0] CLASS_COMMENT = 2'd1;
  localparam logic [1:0] CLASS_TOKEN   = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic [1:0] byte_class;
    logic       token_start;
    logic       token_ended_before;
    logic       token_ends_here;
    logic       quote_unclosed;
  } scan_flags_t;

endpackage

/* rtl/whitespace_token_splitter.sv */
// whitespace token splitter top level: input register, scan logic, result register
// mode and position update as a word moves from the input to the result register
// throughput: one word per cycle while the result register is free or being taken
// both stages advance together whenever the result register is free or being taken
// reset clears the mode to skipping, line and column to 1 and both stages to empty
// a word flagged last puts mode and position back to their reset values
module whitespace_token_splitter #(
  parameter int POSITION_BITS = wts_pkg::POS_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wts_pkg::BYTE_W-1:0]        in_text_byte,
  input  logic                              in_last_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wts_pkg::BYTE_W-1:0]        out_byte_out,
  output logic [1:0]                        out_byte_class,
  output logic                              out_token_start,
  output logic                              out_token_ended_before,
  output logic                              out_token_ends_here,
  output logic                              out_quote_unclosed,
  output logic [wts_pkg::OUT_POS_W-1:0]     out_line_number,
  output logic [wts_pkg::OUT_POS_W-1:0]     out_column_number
);

  localparam int PosW = (POSITION_BITS >= 16) ? 16 : POSITION_BITS;

  logic                       s1_valid_r;
  logic [wts_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_last_r;
  logic                       advance;
  logic                       step;
  wts_pkg::scan_flags_t       flags;
  logic [PosW-1:0]            pos_line;
  logic [PosW-1:0]            pos_column;

  logic                       out_valid_r;
  logic [wts_pkg::BYTE_W-1:0] out_byte_r;
  wts_pkg::scan_flags_t       out_flags_r;
  logic [wts_pkg::OUT_POS_W-1:0] out_line_r;
  logic [wts_pkg::OUT_POS_W-1:0] out_column_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign step     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_last_of_text;
    end
  end

  wts_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .text_byte    (s1_byte_r),
    .last_of_text (s1_last_r),
    .flags        (flags)
  );

  wts_position #(
    .POSITION_BITS (POSITION_BITS)
  ) u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .is_newline   (s1_byte_r == wts_pkg::CHAR_NEWLINE),
    .last_of_text (s1_last_r),
    .line         (pos_line),
    .column       (pos_column)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r   <= s1_byte_r;
      out_flags_r  <= flags;
      out_line_r   <= wts_pkg::OUT_POS_W'(pos_line);
      out_column_r <= wts_pkg::OUT_POS_W'(pos_column);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_byte_out           = out_byte_r;
  assign out_byte_class         = out_flags_r.byte_class;
  assign out_token_start        = out_flags_r.token_start;
  assign out_token_ended_before = out_flags_r.token_ended_before;
  assign out_token_ends_here    = out_flags_r.token_ends_here;
  assign out_quote_unclosed     = out_flags_r.quote_unclosed;
  assign out_line_number        = out_line_r;
  assign out_column_number      = out_column_r;

`ifndef SYNTH
  a_unclosed_is_open_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.quote_unclosed |-> out_flags_r.token_ends_here)
    else $error("unclosed quote reported without an open token");

  a_start_is_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.token_start |-> out_flags_r.byte_class == wts_pkg::CLASS_TOKEN)
    else $error("token start on a byte not classed as token");

  a_ended_not_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.token_ended_before |->
      out_flags_r.byte_class != wts_pkg::CLASS_TOKEN)
    else $error("token end marked on a token byte");

  a_last_resets_position: assert property (@(posedge clk) disable iff (!rst_n)
    step && s1_last_r |=> pos_line == PosW'(1) && pos_column == PosW'(1))
    else $error("position not back to 1 after last byte");
`endif

endmodule

/* rtl/wts_scan.sv */
// scan mode state machine and per-byte classification
module wts_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [wts_pkg::BYTE_W-1:0]    text_byte,
  input  logic                          last_of_text,
  output wts_pkg::scan_flags_t          flags
);

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic [1:0] mode_calc;
  logic       is_sep;
  logic       is_hash;
  logic       is_quote;

  assign is_sep   = (text_byte == wts_pkg::CHAR_SPACE) || (text_byte == wts_pkg::CHAR_TAB) ||
                    (text_byte == wts_pkg::CHAR_NEWLINE);
  assign is_hash  = (text_byte == wts_pkg::CHAR_HASH);
  assign is_quote = (text_byte == wts_pkg::CHAR_QUOTE);

  always_comb begin
    flags     = '0;
    mode_calc = mode_r;
    case (mode_r)
      wts_pkg::MODE_SKIP: begin
        if (is_hash) begin
          flags.byte_class = wts_pkg::CLASS_COMMENT;
          mode_calc        = wts_pkg::MODE_COMMENT;
        end else if (is_sep) begin
          flags.byte_class = wts_pkg::CLASS_SEP;
        end else begin
          flags.byte_class  = wts_pkg::CLASS_TOKEN;
          flags.token_start = 1'b1;
          mode_calc         = is_quote ? wts_pkg::MODE_QUOTED : wts_pkg::MODE_TOKEN;
        end
      end
      wts_pkg::MODE_COMMENT: begin
        flags.byte_class = wts_pkg::CLASS_COMMENT;
        if (text_byte == wts_pkg::CHAR_NEWLINE) begin
          mode_calc = wts_pkg::MODE_SKIP;
        end
      end
      wts_pkg::MODE_TOKEN: begin
        if (is_hash) begin
          flags.byte_class         = wts_pkg::CLASS_COMMENT;
          flags.token_ended_before = 1'b1;
          mode_calc                = wts_pkg::MODE_COMMENT;
        end else if (is_sep) begin
          flags.byte_class         = wts_pkg::CLASS_SEP;
          flags.token_ended_before = 1'b1;
          mode_calc                = wts_pkg::MODE_SKIP;
        end else begin
          flags.byte_class = wts_pkg::CLASS_TOKEN;
          if (is_quote) begin
            mode_calc = wts_pkg::MODE_QUOTED;
          end
        end
      end
      default: begin
        flags.byte_class = wts_pkg::CLASS_TOKEN;
        if (is_quote) begin
          mode_calc = wts_pkg::MODE_TOKEN;
        end
      end
    endcase
    if (last_of_text) begin
      flags.token_ends_here = (mode_calc == wts_pkg::MODE_TOKEN) ||
                              (mode_calc == wts_pkg::MODE_QUOTED);
      flags.quote_unclosed  = (mode_calc == wts_pkg::MODE_QUOTED);
    end
  end

  // end of text drops back to skipping for the next text
  assign mode_nxt = last_of_text ? wts_pkg::MODE_SKIP : mode_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= wts_pkg::MODE_SKIP;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

/* rtl/wts_position.sv */
// saturating line and column counters
module wts_position #(
  parameter int POSITION_BITS = wts_pkg::POS_BITS_DEFAULT
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                step,
  input  logic                                                is_newline,
  input  logic                                                last_of_text,
  output logic [((POSITION_BITS >= 16) ? 16 : POSITION_BITS)-1:0] line,
  output logic [((POSITION_BITS >= 16) ? 16 : POSITION_BITS)-1:0] column
);

  localparam int PosW = (POSITION_BITS >= 16) ? 16 : POSITION_BITS;

  logic [PosW-1:0] line_r;
  logic [PosW-1:0] line_nxt;
  logic [PosW-1:0] column_r;
  logic [PosW-1:0] column_nxt;
  logic [PosW-1:0] line_inc;
  logic [PosW-1:0] column_inc;

  // limit is all ones at this width
  assign line_inc   = (&line_r)   ? line_r   : line_r + 1'b1;
  assign column_inc = (&column_r) ? column_r : column_r + 1'b1;

  always_comb begin
    line_nxt   = line_r;
    column_nxt = column_inc;
    if (last_of_text) begin
      line_nxt   = PosW'(1);
      column_nxt = PosW'(1);
    end else if (is_newline) begin
      line_nxt   = line_inc;
      column_nxt = PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= PosW'(1);
      column_r <= PosW'(1);
    end else if (step) begin
      line_r   <= line_nxt;
      column_r <= column_nxt;
    end
  end

  assign line   = line_r;
  assign column = column_r;

endmodule

/* tb/whitespace_token_splitter_tb.sv */
// self-checking testbench for the whitespace token splitter: directed table and random texts
`timescale 1ns / 100ps

module whitespace_token_splitter_tb;
  import wts_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_WORDS = 820;
  localparam logic [OUT_POS_W-1:0] POS_LIMIT = (POS_BITS_DEFAULT >= 16) ? 16'hFFFF
                                             : OUT_POS_W'((1 << POS_BITS_DEFAULT) - 1);

  typedef struct packed {
    logic [BYTE_W-1:0]    ch;
    scan_flags_t          flags;
    logic [OUT_POS_W-1:0] line;
    logic [OUT_POS_W-1:0] col;
  } scan_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              lst;
    logic              typed;
    scan_result_t      want;
  } text_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_text_byte = '0;
  logic                 in_last_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_byte_out;
  logic [1:0]           out_byte_class;
  logic                 out_token_start;
  logic                 out_token_ended_before;
  logic                 out_token_ends_here;
  logic                 out_quote_unclosed;
  logic [OUT_POS_W-1:0] out_line_number;
  logic [OUT_POS_W-1:0] out_column_number;

  whitespace_token_splitter dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_text_byte           (in_text_byte),
    .in_last_of_text        (in_last_of_text),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_byte_out           (out_byte_out),
    .out_byte_class         (out_byte_class),
    .out_token_start        (out_token_start),
    .out_token_ended_before (out_token_ended_before),
    .out_token_ends_here    (out_token_ends_here),
    .out_quote_unclosed     (out_quote_unclosed),
    .out_line_number        (out_line_number),
    .out_column_number      (out_column_number)
  );

  always #5 clk = ~clk;

  text_word_t   text_q[$];
  scan_result_t scan_exp_q[$];
  text_word_t   cur_word;
  int           err_count = 0;
  int           results_checked = 0;
  int           cycle_count = 0;

  // scanner state mirrored from the block
  logic [1:0]           scan_mode_r = MODE_SKIP;
  logic [OUT_POS_W-1:0] line_r = 1;
  logic [OUT_POS_W-1:0] col_r = 1;

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [OUT_POS_W-1:0] got,
                             input logic [OUT_POS_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // classify one byte and move the scanner state on
  task automatic advance_scanner(input logic [BYTE_W-1:0] ch, input logic lst,
                                 output scan_result_t res);
    logic [1:0] mode;
    logic       is_blank;
    mode = scan_mode_r;
    is_blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_NEWLINE);
    res = '0;
    res.ch = ch;
    res.line = line_r;
    res.col = col_r;
    case (mode)
      MODE_SKIP: begin
        if (ch == CHAR_HASH) begin
          res.flags.byte_class = CLASS_COMMENT;
          mode = MODE_COMMENT;
        end else if (is_blank) begin
          res.flags.byte_class = CLASS_SEP;
        end else begin
          res.flags.byte_class = CLASS_TOKEN;
          res.flags.token_start = 1'b1;
          mode = (ch == CHAR_QUOTE) ? MODE_QUOTED : MODE_TOKEN;
        end
      end
      MODE_COMMENT: begin
        res.flags.byte_class = CLASS_COMMENT;
        if (ch == CHAR_NEWLINE) mode = MODE_SKIP;
      end
      MODE_TOKEN: begin
        if (ch == CHAR_HASH) begin
          res.flags.byte_class = CLASS_COMMENT;
          res.flags.token_ended_before = 1'b1;
          mode = MODE_COMMENT;
        end else if (is_blank) begin
          res.flags.byte_class = CLASS_SEP;
          res.flags.token_ended_before = 1'b1;
          mode = MODE_SKIP;
        end else begin
          res.flags.byte_class = CLASS_TOKEN;
          if (ch == CHAR_QUOTE) mode = MODE_QUOTED;
        end
      end
      default: begin
        res.flags.byte_class = CLASS_TOKEN;
        if (ch == CHAR_QUOTE) mode = MODE_TOKEN;
      end
    endcase
    if (lst) begin
      res.flags.token_ends_here = (mode == MODE_TOKEN) || (mode == MODE_QUOTED);
      res.flags.quote_unclosed = (mode == MODE_QUOTED);
      scan_mode_r = MODE_SKIP;
      line_r = 1;
      col_r = 1;
    end else begin
      scan_mode_r = mode;
      if (ch == CHAR_NEWLINE) begin
        line_r = (line_r >= POS_LIMIT) ? POS_LIMIT : line_r + 1'b1;
        col_r = 1;
      end else begin
        col_r = (col_r >= POS_LIMIT) ? POS_LIMIT : col_r + 1'b1;
      end
    end
  endtask

  function automatic text_word_t plain_row(input logic [BYTE_W-1:0] ch, input logic lst);
    text_word_t w;
    w = '0;
    w.ch = ch;
    w.lst = lst;
    return w;
  endfunction

  function automatic text_word_t typed_row(input logic [BYTE_W-1:0] ch, input logic lst,
                                           input logic [1:0] cls, input logic start,
                                           input logic ended, input logic ends_here,
                                           input logic unclosed,
                                           input logic [OUT_POS_W-1:0] line,
                                           input logic [OUT_POS_W-1:0] col);
    text_word_t w;
    w = plain_row(ch, lst);
    w.typed = 1'b1;
    w.want = {ch, cls, start, ended, ends_here, unclosed, line, col};
    return w;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    scan_result_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_text_byte <= '0;
      in_last_of_text <= 1'b0;
      burst_left = $urandom_range(1, 32);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_scanner(cur_word.ch, cur_word.lst, pred);
        scan_exp_q.push_back(cur_word.typed ? cur_word.want : pred);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || text_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          cur_word = text_q.pop_front();
          in_valid <= 1'b1;
          in_text_byte <= cur_word.ch;
          in_last_of_text <= cur_word.lst;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left = $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // receiver: stretches of always ready, light stalls and heavy stalls
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(8, 64);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (scan_exp_q.size() == 0) begin
        flag_error("result word with nothing expected");
      end else begin
        want = scan_exp_q.pop_front();
        results_checked++;
        check_field("byte_out", out_byte_out, want.ch);
        check_field("byte_class", out_byte_class, want.flags.byte_class);
        check_field("token_start", out_token_start, want.flags.token_start);
        check_field("token_ended_before", out_token_ended_before,
                    want.flags.token_ended_before);
        check_field("token_ends_here", out_token_ends_here, want.flags.token_ends_here);
        check_field("quote_unclosed", out_quote_unclosed, want.flags.quote_unclosed);
        check_field("line_number", out_line_number, want.line);
        check_field("column_number", out_column_number, want.col);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               scan_exp_q.size());
      $display("whitespace_token_splitter regression: fail");
      $finish;
    end
  end

  initial begin
    text_word_t dir_rows[$];
    int         rand_words;
    int         rand_texts;
    int         text_len;
    int         pick;
    logic [BYTE_W-1:0] ch;
    logic       noisy;

    // directed part: quoting, comments, separators, byte extremes, text ends
    dir_rows.push_back(typed_row("a", 1'b0, CLASS_TOKEN, 1, 0, 0, 0, 1, 1));
    dir_rows.push_back(plain_row(CHAR_QUOTE, 1'b0));
    dir_rows.push_back(plain_row(CHAR_SPACE, 1'b0));
    dir_rows.push_back(plain_row(CHAR_HASH, 1'b0));
    dir_rows.push_back(plain_row(CHAR_QUOTE, 1'b0));
    // hash closing a token
    dir_rows.push_back(typed_row(CHAR_HASH, 1'b0, CLASS_COMMENT, 0, 1, 0, 0, 1, 6));
    dir_rows.push_back(plain_row(8'h0d, 1'b0));
    // newline ends the comment and is still a comment byte
    dir_rows.push_back(typed_row(CHAR_NEWLINE, 1'b0, CLASS_COMMENT, 0, 0, 0, 0, 1, 8));
    dir_rows.push_back(typed_row(CHAR_TAB, 1'b0, CLASS_SEP, 0, 0, 0, 0, 2, 1));
    // quote opens a token and a quote at once
    dir_rows.push_back(plain_row(CHAR_QUOTE, 1'b0));
    dir_rows.push_back(plain_row(CHAR_NEWLINE, 1'b0));
    dir_rows.push_back(typed_row(8'h00, 1'b1, CLASS_TOKEN, 0, 0, 1, 1, 3, 1));
    dir_rows.push_back(typed_row(8'hff, 1'b0, CLASS_TOKEN, 1, 0, 0, 0, 1, 1));
    dir_rows.push_back(plain_row(8'h0d, 1'b0));
    dir_rows.push_back(plain_row(CHAR_SPACE, 1'b0));
    dir_rows.push_back(plain_row(CHAR_HASH, 1'b0));
    dir_rows.push_back(plain_row("x", 1'b1));
    dir_rows.push_back(typed_row("z", 1'b1, CLASS_TOKEN, 1, 0, 1, 0, 1, 1));
    dir_rows.push_back(typed_row(CHAR_NEWLINE, 1'b1, CLASS_SEP, 0, 0, 0, 0, 1, 1));
    dir_rows.push_back(plain_row("b", 1'b0));
    dir_rows.push_back(plain_row(CHAR_TAB, 1'b0));
    dir_rows.push_back(plain_row("c", 1'b0));
    dir_rows.push_back(plain_row(CHAR_QUOTE, 1'b1));
    dir_rows.push_back(typed_row(CHAR_HASH, 1'b1, CLASS_COMMENT, 0, 0, 0, 0, 1, 1));
    foreach (dir_rows[i]) text_q.push_back(dir_rows[i]);

    // random texts, mostly shaped like real input, some pure noise
    rand_words = 0;
    rand_texts = 0;
    while (rand_words < RANDOM_WORDS) begin
      text_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < text_len; k++) begin
        pick = $urandom_range(0, 99);
        if (noisy || pick >= 88) ch = BYTE_W'($urandom_range(0, 255));
        else if (pick < 35) ch = BYTE_W'($urandom_range(8'h21, 8'h7e));
        else if (pick < 50) ch = CHAR_SPACE;
        else if (pick < 58) ch = CHAR_TAB;
        else if (pick < 68) ch = CHAR_NEWLINE;
        else if (pick < 75) ch = CHAR_HASH;
        else if (pick < 84) ch = CHAR_QUOTE;
        else ch = 8'h0d;
        text_q.push_back(plain_row(ch, k == text_len - 1));
      end
      rand_words += text_len;
      rand_texts++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid || scan_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d directed words and %0d random words in %0d texts",
             dir_rows.size(), rand_words, rand_texts);
    $display("under bursty input and stalled output; %0d results checked, %0d mismatches",
             results_checked, err_count);
    if (err_count == 0) begin
      $display("whitespace_token_splitter regression: pass");
    end else begin
      $display("whitespace_token_splitter regression: fail");
    end
    $finish;
  end

endmodule
